/* src/i2c_master_bit_engine_defines.svh */
// Assertion macros shared by the I2C master bit engine sources.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication checked at every rising edge outside reset.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked at every rising edge outside reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/i2cm_pkg.sv */
// Package with the types and constants of the I2C master bit engine.
package i2cm_pkg;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;
    localparam logic [7:0]  MAX_BYTES         = 8'd255;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_SETUP,
        PH_START_HOLD,
        PH_LOW0,
        PH_LOW1,
        PH_HIGH,
        PH_STOP_LOW,
        PH_STOP_HIGH
    } t_phase;

    typedef struct packed {
        logic       start_request;
        logic       read_mode;
        logic [6:0] target_address;
        logic [7:0] byte_count;
        logic [7:0] tx_data;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_enable;
        logic       sda_level;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_out_word;

    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_in_stage;

endpackage

/* src/i2cm_in_stage.sv */
// Input register stage of the I2C master bit engine.
module i2cm_in_stage
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    input  logic      i_advance,
    output t_in_stage o_stage
);

    logic     r_valid;
    t_in_word r_word;

    // The register empties whenever its word moves on, so it refills in the same cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

/* src/i2cm_core.sv */
// Bus sequencer of the I2C master bit engine: state registers and one-tick update.
`include "i2c_master_bit_engine_defines.svh"
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  t_in_word    i_word,
    input  logic [15:0] i_half_period,
    output t_out_word   o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_interval, n_interval;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_shift, n_shift;
    logic        r_dir, n_dir;
    logic        r_scl, n_scl;
    logic        r_sda_en, n_sda_en;
    logic        r_sda_lvl, n_sda_lvl;
    logic        r_addr_stage, n_addr_stage;
    logic        r_nack_seen, n_nack_seen;

    logic [16:0] hp;
    logic [16:0] interval_inc;
    logic        master_sends;
    logic        tx_taken;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        done;
    logic        stat;
    logic        en_v;
    logic        lvl_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_interval   <= '0;
            r_bit_cnt    <= '0;
            r_bytes_left <= '0;
            r_shift      <= '0;
            r_dir        <= 1'b0;
            r_scl        <= 1'b1;
            r_sda_en     <= 1'b1;
            r_sda_lvl    <= 1'b1;
            r_addr_stage <= 1'b0;
            r_nack_seen  <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_interval   <= n_interval;
            r_bit_cnt    <= n_bit_cnt;
            r_bytes_left <= n_bytes_left;
            r_shift      <= n_shift;
            r_dir        <= n_dir;
            r_scl        <= n_scl;
            r_sda_en     <= n_sda_en;
            r_sda_lvl    <= n_sda_lvl;
            r_addr_stage <= n_addr_stage;
            r_nack_seen  <= n_nack_seen;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_interval   = r_interval;
        n_bit_cnt    = r_bit_cnt;
        n_bytes_left = r_bytes_left;
        n_shift      = r_shift;
        n_dir        = r_dir;
        n_scl        = r_scl;
        n_sda_en     = r_sda_en;
        n_sda_lvl    = r_sda_lvl;
        n_addr_stage = r_addr_stage;
        n_nack_seen  = r_nack_seen;
        tx_taken     = 1'b0;
        rx_valid     = 1'b0;
        rx_data      = '0;
        done         = 1'b0;
        stat         = 1'b0;
        en_v         = 1'b0;
        lvl_v        = 1'b0;

        // A half period of zero behaves as one tick.
        hp           = (i_half_period == 16'd0) ? 17'd1 : {1'b0, i_half_period};
        interval_inc = {1'b0, r_interval} + 17'd1;
        master_sends = r_addr_stage || !r_dir;

        if (r_phase == PH_IDLE) begin
            n_scl     = 1'b1;
            n_sda_en  = 1'b1;
            n_sda_lvl = 1'b1;
            if (i_word.start_request) begin
                n_dir        = i_word.read_mode;
                n_shift      = {i_word.target_address, i_word.read_mode};
                n_bytes_left = (i_word.byte_count > MAX_BYTES) ? MAX_BYTES
                                                               : i_word.byte_count;
                n_bit_cnt    = '0;
                n_interval   = '0;
                n_addr_stage = 1'b1;
                n_nack_seen  = 1'b0;
                n_phase      = PH_START_SETUP;
            end
        end else if (interval_inc < hp) begin
            n_interval = interval_inc[15:0];
        end else begin
            n_interval = '0;
            case (r_phase)
                PH_START_SETUP: begin
                    n_scl     = 1'b1;
                    n_sda_en  = 1'b1;
                    n_sda_lvl = 1'b0;
                    n_phase   = PH_START_HOLD;
                end
                PH_START_HOLD: begin
                    n_scl     = 1'b0;
                    n_sda_en  = 1'b1;
                    n_sda_lvl = 1'b0;
                    n_phase   = PH_LOW0;
                end
                PH_LOW0: begin
                    if (r_bit_cnt < BITS_PER_BYTE) begin
                        // Data bit, MSB first, or released line while receiving.
                        en_v  = master_sends;
                        lvl_v = r_shift[~r_bit_cnt[2:0]];
                    end else begin
                        // Acknowledge slot: released after a sent byte, driven after
                        // a received one with NACK on the last byte.
                        en_v  = !master_sends;
                        lvl_v = (r_bytes_left == 8'd0);
                    end
                    n_scl     = 1'b0;
                    n_sda_en  = en_v;
                    n_sda_lvl = en_v && lvl_v;
                    n_phase   = PH_LOW1;
                end
                PH_LOW1: begin
                    n_scl   = 1'b1;
                    n_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    n_scl = 1'b0;
                    if (r_bit_cnt < BITS_PER_BYTE) begin
                        if (!master_sends) begin
                            n_shift = {r_shift[6:0], i_word.sda_in};
                            if (r_bit_cnt == BITS_PER_BYTE - 4'd1) begin
                                rx_valid = 1'b1;
                                rx_data  = n_shift;
                                if (r_bytes_left != 8'd0) begin
                                    n_bytes_left = r_bytes_left - 8'd1;
                                end
                            end
                        end
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        n_phase   = PH_LOW0;
                    end else if (master_sends && i_word.sda_in) begin
                        n_nack_seen = 1'b1;
                        n_sda_en    = 1'b1;
                        n_sda_lvl   = 1'b0;
                        n_phase     = PH_STOP_LOW;
                    end else begin
                        n_addr_stage = 1'b0;
                        n_bit_cnt    = '0;
                        n_sda_en     = 1'b1;
                        if (r_bytes_left == 8'd0) begin
                            n_sda_lvl = 1'b0;
                            n_phase   = PH_STOP_LOW;
                        end else begin
                            n_sda_lvl = 1'b1;
                            if (!r_dir) begin
                                n_shift      = i_word.tx_data;
                                tx_taken     = 1'b1;
                                n_bytes_left = r_bytes_left - 8'd1;
                            end
                            n_phase = PH_LOW0;
                        end
                    end
                end
                PH_STOP_LOW: begin
                    n_scl     = 1'b1;
                    n_sda_en  = 1'b1;
                    n_sda_lvl = 1'b0;
                    n_phase   = PH_STOP_HIGH;
                end
                default: begin
                    n_scl     = 1'b1;
                    n_sda_en  = 1'b1;
                    n_sda_lvl = 1'b1;
                    done      = 1'b1;
                    stat      = r_nack_seen;
                    n_phase   = PH_IDLE;
                end
            endcase
        end

        o_result.scl_level  = n_scl;
        o_result.sda_enable = n_sda_en;
        o_result.sda_level  = n_sda_lvl;
        o_result.tx_taken   = tx_taken;
        o_result.rx_valid   = rx_valid;
        o_result.rx_data    = rx_data;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.status     = stat;
    end

    `I2CM_ASSERT_NOW(a_bit_cnt_range, i_clk, i_rst_n, 1'b1,
        r_bit_cnt <= BITS_PER_BYTE, "bit counter beyond the acknowledge slot")
    `I2CM_ASSERT_NOW(a_idle_lines, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_scl && r_sda_en && r_sda_lvl, "bus not released high while idle")
    `I2CM_ASSERT_NOW(a_take_or_receive, i_clk, i_rst_n, tx_taken,
        !rx_valid, "data byte taken and received on the same tick")

endmodule

/* src/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: ports, configuration and result register.
//
// The engine runs an I2C master with a 7-bit address, one input word per tick of
// the bus timer. A word with start_request high while idle begins a transfer:
// start condition, address byte (address and read/write bit), then byte_count data
// bytes written from tx_data or read into rx_data, and a stop condition. Each bit
// cell lasts three intervals of half_period words (SCL low, SCL low with the new
// SDA level, SCL high with sda_in sampled on the last word). A missing slave
// acknowledge ends the transfer with a stop and status 1; during a read the master
// acknowledges every byte but the last. Every input word yields exactly one result
// word describing the lines after that tick. The engine takes one word per cycle
// while the output is not stalled: the input register feeds a single pass of
// next-state logic into the result register, and the sequencer state closes its
// loop in that same cycle. An accepted word waits in the input register, then
// moves into the result register to be taken; back-to-back words flow without a
// bubble while the output is not stalled. half_period resets to 2000 and a value
// of zero counts as one. A write is taken only while no word waits in the input
// register, and it applies from the next accepted word on, also mid-transfer.
`include "i2c_master_bit_engine_defines.svh"
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_half_period,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_request,
    input  logic        i_read_mode,
    input  logic [6:0]  i_target_address,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_tx_data,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_enable,
    output logic        o_sda_level,
    output logic        o_tx_taken,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_data,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_status
);

    logic [15:0] r_half_period;
    logic        r_out_valid;
    t_out_word   r_out;
    t_in_word    in_word;
    t_in_stage   stage;
    t_out_word   result;
    logic        advance;

    // Configuration is taken only while no word waits in the input register, so every
    // word is sequenced with the value that was current when it was accepted.
    assign o_cfg_ready = !stage.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_period <= i_cfg_half_period;
        end
    end

    assign in_word.start_request  = i_start_request;
    assign in_word.read_mode      = i_read_mode;
    assign in_word.target_address = i_target_address;
    assign in_word.byte_count     = i_byte_count;
    assign in_word.tx_data        = i_tx_data;
    assign in_word.sda_in         = i_sda_in;

    // A registered word moves into the result register when that register is free
    // or is being emptied in the same cycle.
    assign advance = stage.valid && (!r_out_valid || i_out_ready);

    i2cm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_word    (in_word),
        .i_advance (advance),
        .o_stage   (stage)
    );

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_word        (stage.word),
        .i_half_period (r_half_period),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_out.scl_level;
    assign o_sda_enable = r_out.sda_enable;
    assign o_sda_level  = r_out.sda_level;
    assign o_tx_taken   = r_out.tx_taken;
    assign o_rx_valid   = r_out.rx_valid;
    assign o_rx_data    = r_out.rx_data;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;

    `I2CM_ASSERT_NOW(a_status_with_done, i_clk, i_rst_n, o_out_valid && o_status,
        o_done_res, "status reported without the end of a transfer")
    `I2CM_ASSERT_NOW(a_done_releases_bus, i_clk, i_rst_n, o_out_valid && o_done_res,
        !o_busy_res && o_scl_level && o_sda_enable && o_sda_level,
        "transfer ended without an idle bus")
    `I2CM_ASSERT_NEXT(a_done_reaches_output, i_clk, i_rst_n, advance && result.done_res,
        o_out_valid && o_done_res && !o_tx_taken && !o_rx_valid,
        "end of transfer lost on the way to the output")

endmodule

/* dv/i2cm_tick_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts every result word of the I2C master bit engine and compares it.
module i2cm_tick_checker
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_half_period,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_word   i_out_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int PRINT_CAP = 50;

    // Shadow copy of the register and of the bus sequencer.
    logic [15:0] half_period_q;
    t_phase      phase_q;
    logic [15:0] tick_q;
    logic [3:0]  bit_q;
    logic [7:0]  left_q;
    logic [7:0]  shift_q;
    logic        dir_q;
    logic        addr_q;
    logic        nack_q;
    logic        scl_q;
    logic        en_q;
    logic        lvl_q;

    t_out_word   expected_lines[$];
    t_out_word   predicted;
    t_out_word   wanted;

    task automatic drive_lines(input logic scl, input logic en, input logic lvl);
        scl_q = scl;
        en_q  = en;
        lvl_q = en & lvl;
    endtask

    task automatic predict_tick(input t_in_word w, output t_out_word r);
        logic [15:0] hp;
        logic        master_tx;
        r         = '0;
        hp        = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
        master_tx = addr_q || !dir_q;
        if (phase_q == PH_IDLE) begin
            drive_lines(1'b1, 1'b1, 1'b1);
            if (w.start_request) begin
                dir_q   = w.read_mode;
                shift_q = {w.target_address, w.read_mode};
                left_q  = (w.byte_count > MAX_BYTES) ? MAX_BYTES : w.byte_count;
                bit_q   = '0;
                tick_q  = '0;
                addr_q  = 1'b1;
                nack_q  = 1'b0;
                phase_q = PH_START_SETUP;
            end
        end else if ({1'b0, tick_q} + 17'd1 < {1'b0, hp}) begin
            tick_q = tick_q + 16'd1;
        end else begin
            tick_q = '0;
            case (phase_q)
                PH_START_SETUP: begin
                    drive_lines(1'b1, 1'b1, 1'b0);
                    phase_q = PH_START_HOLD;
                end
                PH_START_HOLD: begin
                    drive_lines(1'b0, 1'b1, 1'b0);
                    phase_q = PH_LOW0;
                end
                PH_LOW0: begin
                    if (bit_q < BITS_PER_BYTE) begin
                        if (master_tx) drive_lines(1'b0, 1'b1, shift_q[4'd7 - bit_q]);
                        else drive_lines(1'b0, 1'b0, 1'b0);
                    end else begin
                        // Acknowledge cell: released for the slave, or driven by us on a read.
                        if (master_tx) drive_lines(1'b0, 1'b0, 1'b0);
                        else drive_lines(1'b0, 1'b1, left_q == 8'd0);
                    end
                    phase_q = PH_LOW1;
                end
                PH_LOW1: begin
                    scl_q   = 1'b1;
                    phase_q = PH_HIGH;
                end
                PH_HIGH: begin
                    scl_q = 1'b0;
                    if (bit_q < BITS_PER_BYTE) begin
                        if (!master_tx) begin
                            shift_q = {shift_q[6:0], w.sda_in};
                            if (bit_q == BITS_PER_BYTE - 4'd1) begin
                                r.rx_valid = 1'b1;
                                r.rx_data  = shift_q;
                                if (left_q > 8'd0) left_q = left_q - 8'd1;
                            end
                        end
                        bit_q   = bit_q + 4'd1;
                        phase_q = PH_LOW0;
                    end else if (master_tx && w.sda_in) begin
                        nack_q = 1'b1;
                        drive_lines(1'b0, 1'b1, 1'b0);
                        phase_q = PH_STOP_LOW;
                    end else begin
                        addr_q = 1'b0;
                        bit_q  = '0;
                        if (left_q == 8'd0) begin
                            drive_lines(1'b0, 1'b1, 1'b0);
                            phase_q = PH_STOP_LOW;
                        end else begin
                            drive_lines(1'b0, 1'b1, 1'b1);
                            if (!dir_q) begin
                                shift_q    = w.tx_data;
                                r.tx_taken = 1'b1;
                                left_q     = left_q - 8'd1;
                            end
                            phase_q = PH_LOW0;
                        end
                    end
                end
                PH_STOP_LOW: begin
                    drive_lines(1'b1, 1'b1, 1'b0);
                    phase_q = PH_STOP_HIGH;
                end
                default: begin
                    drive_lines(1'b1, 1'b1, 1'b1);
                    r.done_res = 1'b1;
                    r.status   = nack_q;
                    phase_q    = PH_IDLE;
                end
            endcase
        end
        r.scl_level  = scl_q;
        r.sda_enable = en_q;
        r.sda_level  = lvl_q;
        r.busy_res   = (phase_q != PH_IDLE);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= PRINT_CAP)
                $display("%0t ns: result word %0d, %s expected %0h, actual %0h",
                         $time, o_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_period_q = HALF_PERIOD_RESET;
            phase_q       = PH_IDLE;
            tick_q        = '0;
            bit_q         = '0;
            left_q        = '0;
            shift_q       = '0;
            dir_q         = 1'b0;
            addr_q        = 1'b0;
            nack_q        = 1'b0;
            drive_lines(1'b1, 1'b1, 1'b1);
            expected_lines.delete();
            o_fail_count  = 0;
            o_checked     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) half_period_q = i_cfg_half_period;
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_in_word, predicted);
                expected_lines.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_lines.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= PRINT_CAP)
                        $display("%0t ns: result word with nothing expected, expected none, actual %0h",
                                 $time, i_out_word);
                end else begin
                    wanted = expected_lines.pop_front();
                    compare_field("scl_level", wanted.scl_level, i_out_word.scl_level);
                    compare_field("sda_enable", wanted.sda_enable, i_out_word.sda_enable);
                    compare_field("sda_level", wanted.sda_level, i_out_word.sda_level);
                    compare_field("tx_taken", wanted.tx_taken, i_out_word.tx_taken);
                    compare_field("rx_valid", wanted.rx_valid, i_out_word.rx_valid);
                    compare_field("rx_data", wanted.rx_data, i_out_word.rx_data);
                    compare_field("busy_res", wanted.busy_res, i_out_word.busy_res);
                    compare_field("done_res", wanted.done_res, i_out_word.done_res);
                    compare_field("status", wanted.status, i_out_word.status);
                    o_checked++;
                end
            end
        end
        o_pending = expected_lines.size();
    end

endmodule

/* dv/tb_i2c_master_bit_engine.sv */
`timescale 1ns / 100ps
// Testbench top of the I2C master bit engine: clock, reset, stimulus and verdict.
module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    // The run is stopped here at the latest; a clean run needs a small fraction of it.
    localparam int RUN_LIMIT_NS = 20_000_000;
    // Words offered in the whole run before the random part stops.
    localparam int ITEM_BUDGET  = 1850;
    // One in this many transfer words makes the sender wait for every result.
    localparam int DRAIN_ODDS   = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_half_period;
    logic        in_valid;
    logic        in_ready;
    t_in_word    drv_word;
    logic        out_valid;
    logic        out_ready;
    logic        scl_level;
    logic        sda_enable;
    logic        sda_level;
    logic        tx_taken;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        busy_res;
    logic        done_res;
    logic        status;

    int          fail_count;
    int          pending;
    int          checked;

    // Stimulus bookkeeping.
    logic        sending;
    logic        calm;
    logic [15:0] hp_now;
    int          burst_left;
    int          words_sent;
    int          transfers;
    int          read_xfers;
    int          nack_xfers;

    i2c_master_bit_engine u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_half_period (cfg_half_period),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_start_request   (drv_word.start_request),
        .i_read_mode       (drv_word.read_mode),
        .i_target_address  (drv_word.target_address),
        .i_byte_count      (drv_word.byte_count),
        .i_tx_data         (drv_word.tx_data),
        .i_sda_in          (drv_word.sda_in),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_scl_level       (scl_level),
        .o_sda_enable      (sda_enable),
        .o_sda_level       (sda_level),
        .o_tx_taken        (tx_taken),
        .o_rx_valid        (rx_valid),
        .o_rx_data         (rx_data),
        .o_busy_res        (busy_res),
        .o_done_res        (done_res),
        .o_status          (status)
    );

    // The checker sits beside the block and watches all three channels.
    i2cm_tick_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_half_period (cfg_half_period),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_word         (drv_word),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_word        ({scl_level, sda_enable, sda_level, tx_taken, rx_valid,
                             rx_data, busy_res, done_res, status}),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A hung handshake or a lost result word ends the run here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // The receiver stalls on its own pattern: again and again it picks a fresh
    // 16-bit ready pattern, which may be all ones, random, mostly ready or a long
    // stall. During calm phases it never stalls.
    initial begin
        logic [15:0] pat;
        int          kind;
        out_ready = 1'b0;
        forever begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: pat = 16'hFFFF;
                1: pat = 16'($urandom);
                2: pat = 16'($urandom) | 16'($urandom);
                default: pat = 16'h00FF;
            endcase
            for (int k = 0; k < 64; k++) begin
                @(negedge i_clk);
                out_ready <= calm ? 1'b1 : pat[k % 16];
            end
        end
    end

    function automatic t_in_word random_word();
        t_in_word w;
        w.start_request  = 1'($urandom_range(0, 1));
        w.read_mode      = 1'($urandom_range(0, 1));
        w.target_address = 7'($urandom);
        w.byte_count     = 8'($urandom);
        w.tx_data        = 8'($urandom);
        w.sda_in         = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offers one word and returns at the falling edge after it was taken. The
    // sender works in bursts, and valid may drop between bursts.
    // Valid is only ever assigned once per falling edge.
    task automatic put_word(input t_in_word w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = calm ? 0 : $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0) begin
            if (sending) in_valid <= 1'b0;
            sending = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        drv_word <= w;
        sending   = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and always lets one falling edge pass, so that valid is
    // never lowered and raised within the same time step.
    task automatic sender_stop();
        if (sending) in_valid <= 1'b0;
        sending = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        sender_stop();
        while (pending != 0) @(negedge i_clk);
    endtask

    // The register is only written with every result in.
    task automatic write_half_period(input logic [15:0] value);
        drain_results();
        cfg_valid       <= 1'b1;
        cfg_half_period <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        hp_now     = value;
    endtask

    // Words offered while idle without a start request; the engine ignores them.
    task automatic idle_words(input int n);
        t_in_word w;
        repeat (n) begin
            w               = random_word();
            w.start_request = 1'b0;
            put_word(w);
        end
    endtask

    // Runs one whole transfer, word by word, from the start word up to the word
    // on which the stop completes. The testbench plays the slave: it knows that
    // bit cell j of the transfer is sampled on word (3*j + 5) * half_period, so it
    // puts the acknowledge or the read data on exactly those words and noise on
    // all the others. A missing acknowledge is placed on the cell after byte
    // nack_byte (0 is the address byte); a negative value means every byte is
    // acknowledged. With use_pat set, written and read bytes all equal pat.
    task automatic run_transfer(input logic rd, input logic [6:0] addr, input logic [7:0] cnt,
                                input int nack_byte, input logic use_pat,
                                input logic [7:0] pat);
        t_in_word w;
        int       hp_e;
        int       cells;
        int       end_word;
        int       slot;
        int       cell_idx;
        hp_e     = (hp_now == 16'd0) ? 1 : int'(hp_now);
        cells    = (nack_byte >= 0) ? 9 * (nack_byte + 1) : 9 * (int'(cnt) + 1);
        end_word = (3 * cells + 4) * hp_e;
        transfers++;
        if (rd) read_xfers++;
        if (nack_byte >= 0) nack_xfers++;
        for (int n = 0; n <= end_word; n++) begin
            w = random_word();
            if (n == 0) begin
                w.start_request  = 1'b1;
                w.read_mode      = rd;
                w.target_address = addr;
                w.byte_count     = cnt;
            end
            if (use_pat) w.tx_data = pat;
            slot = n / hp_e;
            if (n % hp_e == 0 && slot >= 5 && (slot - 5) % 3 == 0) begin
                cell_idx = (slot - 5) / 3;
                if (cell_idx % 9 == 8) w.sda_in = (cell_idx / 9 == nack_byte);
                else if (use_pat) w.sda_in = pat[7 - cell_idx % 9];
            end
            // Now and then the sender waits until the result stream has caught up.
            if ($urandom_range(0, DRAIN_ODDS - 1) == 0) drain_results();
            put_word(w);
        end
    endtask

    initial begin
        int          pick;
        logic [7:0]  cnt;
        logic        rd;
        int          nack_byte;
        logic [15:0] hp_pick;
        t_in_word    w;

        // Every input of the block is known from time zero.
        i_rst_n         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_half_period = HALF_PERIOD_RESET;
        in_valid        = 1'b0;
        drv_word        = '0;
        sending         = 1'b0;
        calm            = 1'b0;
        hp_now          = HALF_PERIOD_RESET;
        burst_left      = 0;
        words_sent      = 0;
        transfers       = 0;
        read_xfers      = 0;
        nack_xfers      = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First the reset value of the half period: an address-only
        // write to the highest address holds its start condition for 2000 words, so
        // after a few dozen words the register is set to one in the middle of the
        // transfer, which then ends at the fast timing with every cell acknowledged.
        idle_words(4);
        w                = random_word();
        w.start_request  = 1'b1;
        w.read_mode      = 1'b0;
        w.target_address = 7'h7F;
        w.byte_count     = 8'd0;
        put_word(w);
        transfers++;
        repeat (40) begin
            w        = random_word();
            w.sda_in = 1'b0;
            put_word(w);
        end
        write_half_period(16'd1);
        repeat (40) begin
            w               = random_word();
            w.start_request = 1'b0;
            w.sda_in        = 1'b0;
            put_word(w);
        end

        // Writes and reads of all-ones and all-zeros bytes at the fastest timing.
        run_transfer(1'b0, 7'h00, 8'd2, -1, 1'b1, 8'hFF);
        run_transfer(1'b0, 7'h2A, 8'd2, -1, 1'b1, 8'h00);
        run_transfer(1'b1, 7'h55, 8'd3, -1, 1'b1, 8'hFF);
        run_transfer(1'b1, 7'h2A, 8'd2, -1, 1'b1, 8'h00);

        // Missing acknowledge on the address byte, for a write and for a read,
        // then on the second data byte of a write.
        run_transfer(1'b0, 7'h11, 8'd1, 0, 1'b0, 8'h00);
        run_transfer(1'b1, 7'h22, 8'd4, 0, 1'b0, 8'h00);
        run_transfer(1'b0, 7'h33, 8'd3, 2, 1'b0, 8'h00);

        // A read of zero bytes stops right after the address acknowledge.
        run_transfer(1'b1, 7'h44, 8'd0, -1, 1'b0, 8'h00);

        // A half period of zero must behave like one.
        write_half_period(16'd0);
        run_transfer(1'b0, 7'h5A, 8'd1, -1, 1'b0, 8'h00);

        // The largest half period is only held while idle; a transfer would be too long.
        write_half_period(16'hFFFF);
        idle_words(6);
        write_half_period(16'd3);
        run_transfer(1'b1, 7'h01, 8'd2, -1, 1'b0, 8'h00);

        // The largest byte count, cut short by a missing acknowledge on the
        // second data byte.
        write_half_period(16'd1);
        run_transfer(1'b0, 7'h3C, 8'd255, 2, 1'b0, 8'h00);

        // Random part. Each phase picks a half period, mostly short, and runs a
        // few transfers with random direction, address, length and data. About
        // one transfer in five ends on a missing acknowledge.
        while (words_sent < ITEM_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) hp_pick = 16'd1;
            else if (pick < 80) hp_pick = 16'd2;
            else if (pick < 90) hp_pick = 16'($urandom_range(3, 5));
            else if (pick < 95) hp_pick = 16'd0;
            else hp_pick = 16'($urandom_range(6, 9));
            write_half_period(hp_pick);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if (words_sent >= ITEM_BUDGET) break;
                rd   = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 40) cnt = 8'($urandom_range(0, 1));
                else if (pick < 80) cnt = 8'($urandom_range(2, 4));
                else if (pick < 97) cnt = 8'($urandom_range(5, 12));
                else cnt = 8'($urandom_range(13, 30));
                nack_byte = -1;
                if ($urandom_range(0, 4) == 0) nack_byte = rd ? 0 : $urandom_range(0, cnt);
                run_transfer(rd, 7'($urandom), cnt, nack_byte, 1'b0, 8'h00);
                idle_words($urandom_range(0, 3));
            end
        end
        calm = 1'b0;

        // All words are in; wait for the last results and a little beyond.
        drain_results();
        repeat (20) @(negedge i_clk);

        $display("Ran %0d transfers (%0d reads, %0d ended by a missing acknowledge).",
                 transfers, read_xfers, nack_xfers);
        $display("Checked %0d of %0d words; half periods 0 to 9, 2000, 65535, one retimed.",
                 checked, words_sent);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
